@@ rtl/core/aphit_pkg.sv @@
// Shared types, codes and helpers for the point-in-box hit table.
package aphit_pkg;

   localparam int MAX_BOXES   = 16;
   localparam int COORD_WIDTH = 20;
   localparam int INDEX_WIDTH = 4;
   localparam int TYPE_WIDTH  = 2;
   localparam int SLOT_WIDTH  = $clog2(MAX_BOXES);
   localparam int COUNT_WIDTH = $clog2(MAX_BOXES + 1);
   localparam int CMP_WIDTH   = COUNT_WIDTH + INDEX_WIDTH;
   localparam int NUM_AXES    = 3;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [COORD_WIDTH:0]   span_type;
   typedef logic signed [COORD_WIDTH+1:0] wide_type;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_MOVE   = 2'd2,
      ACT_CHECK  = 2'd3
   } action_type;

   localparam logic [1:0] STAT_DONE       = 2'd0;
   localparam logic [1:0] STAT_FULL       = 2'd1;
   localparam logic [1:0] STAT_NOT_IN_USE = 2'd2;

   typedef struct packed {
      logic [1:0]            action;
      logic [INDEX_WIDTH-1:0] box_index;
      logic [TYPE_WIDTH-1:0]  box_type;
      coord_type             min_x;
      coord_type             min_y;
      coord_type             min_z;
      coord_type             max_x;
      coord_type             max_y;
      coord_type             max_z;
      coord_type             point_x;
      coord_type             point_y;
      coord_type             point_z;
   } req_type;

   typedef struct packed {
      logic [1:0]             status;
      logic                   hit;
      logic [INDEX_WIDTH-1:0] hit_index;
      logic [INDEX_WIDTH-1:0] added_index;
   } rsp_type;

   // Item travelling down the row of cells
   typedef struct packed {
      logic                  valid;
      req_type               req;
      logic [SLOT_WIDTH-1:0] slot;
      rsp_type               rsp;
   } pkt_type;

   // Saturate a widened coordinate back into the coordinate range
   function automatic coord_type clamp_coord(wide_type v);
      coord_type r;
      if (v[COORD_WIDTH+1:COORD_WIDTH-1] == '0 || v[COORD_WIDTH+1:COORD_WIDTH-1] == '1) begin
         r = v[COORD_WIDTH-1:0];
      end else if (v[COORD_WIDTH+1]) begin
         r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

@@ rtl/core/aphit_cell.sv @@
// One slot of the box table: holds a box and acts on the item passing through.
module aphit_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [aphit_pkg::SLOT_WIDTH-1:0]    cell_index,
   input  logic [aphit_pkg::COUNT_WIDTH-1:0]   box_count,
   input  aphit_pkg::pkt_type                  pkt_in,
   output aphit_pkg::pkt_type                  pkt_out
);

   aphit_pkg::coord_type               lo_ff [aphit_pkg::NUM_AXES];
   aphit_pkg::coord_type               hi_ff [aphit_pkg::NUM_AXES];
   aphit_pkg::coord_type               lo_in [aphit_pkg::NUM_AXES];
   aphit_pkg::coord_type               hi_in [aphit_pkg::NUM_AXES];
   aphit_pkg::coord_type               pt    [aphit_pkg::NUM_AXES];
   aphit_pkg::coord_type               bmin  [aphit_pkg::NUM_AXES];
   aphit_pkg::coord_type               bmax  [aphit_pkg::NUM_AXES];
   logic [aphit_pkg::TYPE_WIDTH-1:0]   kind_ff;
   logic                               active_ff;
   logic                               valid_ff;
   aphit_pkg::pkt_type                 pkt_ff;
   aphit_pkg::pkt_type                 pkt_in_next;
   aphit_pkg::span_type                span;
   aphit_pkg::span_type                half;
   logic                               own_slot;
   logic                               in_table;
   logic                               enclosed;
   logic                               do_add;
   logic                               do_remove;
   logic                               do_move;
   logic                               do_check;

   always_comb begin
      pt[0]   = pkt_in.req.point_x;
      pt[1]   = pkt_in.req.point_y;
      pt[2]   = pkt_in.req.point_z;
      bmin[0] = pkt_in.req.min_x;
      bmin[1] = pkt_in.req.min_y;
      bmin[2] = pkt_in.req.min_z;
      bmax[0] = pkt_in.req.max_x;
      bmax[1] = pkt_in.req.max_y;
      bmax[2] = pkt_in.req.max_z;
   end

   assign own_slot  = pkt_in.valid && (pkt_in.rsp.status == aphit_pkg::STAT_DONE) &&
                      (pkt_in.slot == cell_index);
   assign in_table  = aphit_pkg::COUNT_WIDTH'(cell_index) < box_count;
   assign do_add    = own_slot && (pkt_in.req.action == aphit_pkg::ACT_ADD);
   assign do_remove = own_slot && (pkt_in.req.action == aphit_pkg::ACT_REMOVE);
   assign do_move   = own_slot && (pkt_in.req.action == aphit_pkg::ACT_MOVE);
   assign do_check  = pkt_in.valid && (pkt_in.req.action == aphit_pkg::ACT_CHECK) &&
                      !pkt_in.rsp.hit && in_table && active_ff &&
                      (kind_ff == pkt_in.req.box_type);

   // Recenter on the point with half the old span on each side; half rounds toward minus infinity
   always_comb begin
      span     = '0;
      half     = '0;
      enclosed = 1'b1;
      for (int a = 0; a < aphit_pkg::NUM_AXES; a++) begin
         span     = aphit_pkg::span_type'(hi_ff[a]) - aphit_pkg::span_type'(lo_ff[a]);
         half     = span >>> 1;
         lo_in[a] = aphit_pkg::clamp_coord(aphit_pkg::wide_type'(pt[a]) -
                                           aphit_pkg::wide_type'(half));
         hi_in[a] = aphit_pkg::clamp_coord(aphit_pkg::wide_type'(pt[a]) +
                                           aphit_pkg::wide_type'(half));
         enclosed = enclosed && (pt[a] >= lo_ff[a]) && (pt[a] <= hi_ff[a]);
      end
   end

   always_comb begin
      pkt_in_next = pkt_in;
      if (do_check && enclosed) begin
         pkt_in_next.rsp.hit       = 1'b1;
         pkt_in_next.rsp.hit_index = aphit_pkg::INDEX_WIDTH'(cell_index);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= pkt_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      pkt_ff <= pkt_in_next;
      if (do_add) begin
         for (int a = 0; a < aphit_pkg::NUM_AXES; a++) begin
            lo_ff[a] <= bmin[a];
            hi_ff[a] <= bmax[a];
         end
         kind_ff   <= pkt_in.req.box_type;
         active_ff <= 1'b1;
      end else if (do_move) begin
         for (int a = 0; a < aphit_pkg::NUM_AXES; a++) begin
            lo_ff[a] <= lo_in[a];
            hi_ff[a] <= hi_in[a];
         end
      end else if (do_remove) begin
         active_ff <= 1'b0;
      end
   end

   always_comb begin
      pkt_out       = pkt_ff;
      pkt_out.valid = valid_ff;
   end

endmodule

@@ rtl/core/aabb_point_hit_table_core.sv @@
// Top level of the point-in-box hit table: command intake and the row of slot cells.
//
// Usage: present an item on req_data and raise start; the item is taken at a
// rising edge where start is high and busy is low. busy stays high from then
// until the result has been shown. The result appears on rsp_data with
// rsp_valid high for exactly one cycle; the receiver cannot hold it off.
// Add, remove, move and check all give one result.
//
// Flow: the item is registered at intake, then passes through one slot cell per
// cycle; rsp_valid is high as it leaves the last of the MAX_BOXES cells. busy drops
// at the edge that ends that cycle; only then can a new item be taken, so one
// item at a time is in flight in the row of cells.
//
// Status for add and for remove or move is settled at intake against the box
// count; each cell writes, clears or recenters its own box, and a check
// collects the first matching slot as the item walks the row.
//
// Reset empties the table (box count zero) and drops any item in flight;
// box contents are left as they were and are never read before being added.
module aabb_point_hit_table_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  aphit_pkg::req_type req_data,
   output logic               rsp_valid,
   output aphit_pkg::rsp_type rsp_data
);

   logic [aphit_pkg::COUNT_WIDTH-1:0] count_ff;
   logic [aphit_pkg::COUNT_WIDTH-1:0] count_in;
   logic                              busy_ff;
   logic                              head_valid_ff;
   aphit_pkg::pkt_type                head_ff;
   aphit_pkg::pkt_type                head_in;
   aphit_pkg::pkt_type                chain [aphit_pkg::MAX_BOXES+1];
   logic                              accept;
   logic                              full;
   logic                              slot_bad;

   assign accept   = start && !busy_ff;
   assign full     = count_ff == aphit_pkg::COUNT_WIDTH'(aphit_pkg::MAX_BOXES);
   assign slot_bad = aphit_pkg::CMP_WIDTH'(req_data.box_index) >=
                     aphit_pkg::CMP_WIDTH'(count_ff);

   always_comb begin
      head_in                 = '0;
      head_in.valid           = 1'b1;
      head_in.req             = req_data;
      head_in.slot            = aphit_pkg::SLOT_WIDTH'(req_data.box_index);
      head_in.rsp.status      = aphit_pkg::STAT_DONE;
      count_in                = count_ff;
      unique case (req_data.action) inside
         aphit_pkg::ACT_ADD: begin
            if (full) begin
               head_in.rsp.status = aphit_pkg::STAT_FULL;
            end else begin
               head_in.slot            = aphit_pkg::SLOT_WIDTH'(count_ff);
               head_in.rsp.added_index = aphit_pkg::INDEX_WIDTH'(count_ff);
               count_in                = aphit_pkg::COUNT_WIDTH'(count_ff + 1'b1);
            end
         end
         aphit_pkg::ACT_REMOVE, aphit_pkg::ACT_MOVE: begin
            if (slot_bad) begin
               head_in.rsp.status = aphit_pkg::STAT_NOT_IN_USE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         busy_ff       <= 1'b0;
         head_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
            busy_ff  <= 1'b1;
         end else if (chain[aphit_pkg::MAX_BOXES].valid) begin
            busy_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         head_ff <= head_in;
      end
   end

   always_comb begin
      chain[0]       = head_ff;
      chain[0].valid = head_valid_ff;
   end

   for (genvar g = 0; g < aphit_pkg::MAX_BOXES; g++) begin : g_cell
      aphit_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (aphit_pkg::SLOT_WIDTH'(g)),
         .box_count  (count_ff),
         .pkt_in     (chain[g]),
         .pkt_out    (chain[g+1])
      );
   end

   assign busy      = busy_ff;
   assign rsp_valid = chain[aphit_pkg::MAX_BOXES].valid;
   assign rsp_data  = chain[aphit_pkg::MAX_BOXES].rsp;

endmodule

@@ rtl/core/aphit_checker.sv @@
// Port-level checks for the hit table core, bound to the top level.
module aphit_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input aphit_pkg::rsp_type rsp_data
);

   // An accepted item raises busy
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted item");

   // A result only shows while an item is in flight
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe while not busy");

   // The result strobe lasts one cycle and releases busy
   a_rsp_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("result strobe held or busy kept after result");

   // A hit is always a completed item with status done and added index zero
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (rsp_data.status == aphit_pkg::STAT_DONE &&
                                       rsp_data.added_index == '0))
      else $error("hit reported with a non-done status or an added slot");

endmodule

bind aabb_point_hit_table_core aphit_checker u_aphit_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
